// ===== src/boundary_tag_heap_allocator_defines.svh =====
// Assertion helpers for the heap allocator
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_DEFINES_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BTH_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("heap allocator check failed");
// next-cycle implication
`define BTH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("heap allocator check failed");
`else
`define BTH_ASSERT_IMPL(label, ante, cons)
`define BTH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/bth_pkg.sv =====
package bth_pkg;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [16:0] CHUNK_RESET = 17'd4096;

    typedef struct packed {
        logic        kind;
        logic [16:0] request_bytes;
        logic [15:0] block_offset;
    } in_t;

    typedef struct packed {
        logic [15:0] payload_offset;
        logic [1:0]  status;
    } out_t;

    // finished result from the sequencer
    typedef struct packed {
        logic valid;
        out_t data;
    } seq_res_t;

    // memory command
    typedef struct packed {
        logic rd;
        logic wr;
    } ram_cmd_t;

endpackage

// ===== src/boundary_tag_heap_allocator.sv =====
// Channel   Ports                          Moves
// input     s_valid s_ready s_data         one allocate or free request
// result    m_valid m_ready m_data         one payload offset and status
// config    cfg_we cfg_wdata               chunk_bytes, no handshake
//
// Allocate: a first-fit scan reads the block headers in turn, then the block
// is placed; if none fits, the heap is grown first. A zero-size allocate
// returns its status with no heap access. Free: checks the tags, then coalesces.
// The heap memory has a single port, so each step does one read or one write.
// After reset a pass writes the prologue and epilogue words.
// A finished result waits in the output register; the next request is taken
// once the sequencer has handed its result over.
`include "boundary_tag_heap_allocator_defines.svh"

module boundary_tag_heap_allocator #(
    parameter int HEAP_WORDS = 16384
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bth_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output bth_pkg::out_t m_data,
    input  logic          cfg_we,
    input  logic [16:0]   cfg_wdata
);
    localparam int WIW = $clog2(HEAP_WORDS);
    localparam int AW  = (WIW + 4 > 19) ? WIW + 4 : 19;

    logic [16:0]       chunk_reg;
    logic              m_valid_reg;
    bth_pkg::out_t     m_data_reg;
    bth_pkg::seq_res_t res;
    logic              res_ready;
    bth_pkg::ram_cmd_t mem_cmd;
    logic [AW-1:0]     mem_addr;
    logic [31:0]       mem_wdata;
    logic [31:0]       mem_rdata;

    assign res_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // config register and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_reg   <= bth_pkg::CHUNK_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                chunk_reg <= cfg_wdata;
            end
            if (res_ready) begin
                m_valid_reg <= res.valid;
            end
        end
        if (res_ready && res.valid) begin
            m_data_reg <= res.data;
        end
    end

    bth_seq #(.HEAP_WORDS(HEAP_WORDS), .AW(AW)) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .chunk     (chunk_reg),
        .res       (res),
        .res_ready (res_ready),
        .mem_cmd   (mem_cmd),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    bth_ram #(.HEAP_WORDS(HEAP_WORDS), .AW(AW)) u_ram (
        .aclk  (aclk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // checks
    `BTH_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `BTH_ASSERT_IMPL(a_fail_no_offset, m_valid && m_data.status != bth_pkg::ST_OK, m_data.payload_offset == 16'd0)
    `BTH_ASSERT_IMPL(a_offset_aligned, m_valid && m_data.payload_offset != 16'd0, m_data.payload_offset[2:0] == 3'd0)
    `BTH_ASSERT_IMPL(a_no_rdwr, mem_cmd.rd, !mem_cmd.wr)

endmodule

// ===== src/bth_ram.sv =====
module bth_ram #(
    parameter int HEAP_WORDS = 16384,
    parameter int AW         = 19
) (
    input  logic              aclk,
    input  bth_pkg::ram_cmd_t cmd,
    input  logic [AW-1:0]     addr,
    input  logic [31:0]       wdata,
    output logic [31:0]       rdata
);
    localparam int WIW = $clog2(HEAP_WORDS);

    logic [31:0]      mem [HEAP_WORDS];
    logic [31:0]      rd_q;
    logic             in_range;
    logic             in_range_reg;
    logic [WIW-1:0]   idx;

    // byte address to word index, out-of-store accesses are dropped
    assign in_range = (addr[AW-1:2] < (AW-2)'(HEAP_WORDS));
    assign idx      = addr[WIW+1:2];

    always_ff @(posedge aclk) begin
        if (cmd.wr && in_range) begin
            mem[idx] <= wdata;
        end
        if (cmd.rd) begin
            rd_q         <= mem[idx];
            in_range_reg <= in_range;
        end
    end

    assign rdata = in_range_reg ? rd_q : 32'd0;

endmodule

// ===== src/bth_seq.sv =====
module bth_seq #(
    parameter int HEAP_WORDS = 16384,
    parameter int AW         = 19
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  bth_pkg::in_t      in_data,
    input  logic [16:0]       chunk,
    output bth_pkg::seq_res_t res,
    input  logic              res_ready,
    output bth_pkg::ram_cmd_t mem_cmd,
    output logic [AW-1:0]     mem_addr,
    output logic [31:0]       mem_wdata,
    input  logic [31:0]       mem_rdata
);
    localparam logic [AW-1:0] HEAP_BYTES = AW'(HEAP_WORDS) << 2;
    localparam logic [AW-1:0] MIN_BLK    = AW'(16);

    localparam logic [4:0] S_INIT  = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_SCAN  = 5'd2;
    localparam logic [4:0] S_GROW  = 5'd3;
    localparam logic [4:0] S_GW1   = 5'd4;
    localparam logic [4:0] S_GW2   = 5'd5;
    localparam logic [4:0] S_F1    = 5'd6;
    localparam logic [4:0] S_F2    = 5'd7;
    localparam logic [4:0] S_F3    = 5'd8;
    localparam logic [4:0] S_MPREV = 5'd9;
    localparam logic [4:0] S_MNEXT = 5'd10;
    localparam logic [4:0] S_MJOIN = 5'd11;
    localparam logic [4:0] S_MFOOT = 5'd12;
    localparam logic [4:0] S_P0    = 5'd13;
    localparam logic [4:0] S_P1    = 5'd14;
    localparam logic [4:0] S_P2    = 5'd15;
    localparam logic [4:0] S_P3    = 5'd16;
    localparam logic [4:0] S_DONE  = 5'd17;

    logic [4:0]      state_reg, state_next;
    logic [1:0]      init_cnt_reg, init_cnt_next;
    logic [AW-1:0]   break_reg, break_next;
    logic [AW-1:0]   bp_reg, bp_next;
    logic [AW-1:0]   need_reg, need_next;
    logic [AW-1:0]   size_reg, size_next;
    logic [31:0]     tag_reg, tag_next;
    logic            kind_reg, kind_next;
    bth_pkg::out_t   res_reg, res_next;

    logic [AW-1:0]   rd_size;
    logic [AW-1:0]   prev_size;
    logic [AW-1:0]   req_sum;
    logic [AW-1:0]   off_ext;
    logic [AW-1:0]   ext;
    logic [AW-1:0]   gsize;
    logic [AW-1:0]   nb;
    logic [AW-1:0]   psize;
    logic [AW-1:0]   msize;
    logic            split;

    function automatic logic [31:0] tag_of(input logic [AW-1:0] sz, input logic a);
        tag_of = {{(32-AW){1'b0}}, sz[AW-1:1], a};
    endfunction

    assign rd_size   = {mem_rdata[AW-1:3], 3'b000};
    assign prev_size = {tag_reg[AW-1:3], 3'b000};
    assign req_sum   = AW'(in_data.request_bytes) + AW'(15);
    assign off_ext   = AW'(in_data.block_offset);
    assign ext       = (need_reg > AW'(chunk)) ? need_reg : AW'(chunk);
    assign gsize     = {ext[AW-1:3], 3'b000} + (ext[2] ? AW'(8) : AW'(0));
    assign nb        = bp_reg + rd_size;
    assign split     = (size_reg >= need_reg + MIN_BLK);
    assign psize     = split ? need_reg : size_reg;
    assign msize     = size_reg + (mem_rdata[0] ? AW'(0) : rd_size)
                     + (tag_reg[0] ? AW'(0) : prev_size);

    assign in_ready  = (state_reg == S_IDLE);
    assign res.valid = (state_reg == S_DONE);
    assign res.data  = res_reg;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        init_cnt_next = init_cnt_reg;
        break_next    = break_reg;
        bp_next       = bp_reg;
        need_next     = need_reg;
        size_next     = size_reg;
        tag_next      = tag_reg;
        kind_next     = kind_reg;
        res_next      = res_reg;
        mem_cmd       = '0;
        mem_addr      = '0;
        mem_wdata     = '0;
        unique case (state_reg)
            S_INIT: begin
                // prologue and epilogue words
                mem_cmd.wr    = 1'b1;
                mem_addr      = AW'({init_cnt_reg, 2'b00});
                mem_wdata     = (init_cnt_reg == 2'd0) ? 32'd0 :
                                (init_cnt_reg == 2'd3) ? 32'd1 : 32'd9;
                init_cnt_next = init_cnt_reg + 2'd1;
                if (init_cnt_reg == 2'd3) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    kind_next = in_data.kind;
                    res_next  = '{payload_offset: 16'd0, status: bth_pkg::ST_OK};
                    if (in_data.kind == bth_pkg::KIND_ALLOC) begin
                        if (in_data.request_bytes == 17'd0) begin
                            res_next.status = bth_pkg::ST_ZERO;
                            state_next      = S_DONE;
                        end else begin
                            need_next   = (in_data.request_bytes <= 17'd8) ? MIN_BLK
                                        : {req_sum[AW-1:3], 3'b000};
                            bp_next     = AW'(8);
                            mem_cmd.rd  = 1'b1;
                            mem_addr    = AW'(4);
                            state_next  = S_SCAN;
                        end
                    end else begin
                        bp_next = off_ext;
                        if (off_ext[2:0] == 3'd0 && off_ext >= MIN_BLK
                            && off_ext < break_reg) begin
                            mem_cmd.rd = 1'b1;
                            mem_addr   = off_ext - AW'(4);
                            state_next = S_F1;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_SCAN: begin
                // one header per cycle
                priority if (rd_size == '0) begin
                    state_next = S_GROW;
                end else if (!mem_rdata[0] && need_reg <= rd_size) begin
                    size_next  = rd_size;
                    state_next = S_P0;
                end else begin
                    bp_next = nb;
                    if (nb >= break_reg) begin
                        state_next = S_GROW;
                    end else begin
                        mem_cmd.rd = 1'b1;
                        mem_addr   = nb - AW'(4);
                    end
                end
            end
            S_GROW: begin
                if (break_reg > HEAP_BYTES || gsize > HEAP_BYTES - break_reg) begin
                    res_next.status = bth_pkg::ST_FULL;
                    state_next      = S_DONE;
                end else begin
                    bp_next    = break_reg;
                    size_next  = gsize;
                    mem_cmd.wr = 1'b1;
                    mem_addr   = break_reg - AW'(4);
                    mem_wdata  = tag_of(gsize, 1'b0);
                    state_next = S_GW1;
                end
            end
            S_GW1: begin
                mem_cmd.wr = 1'b1;
                mem_addr   = bp_reg + size_reg - AW'(8);
                mem_wdata  = tag_of(size_reg, 1'b0);
                state_next = S_GW2;
            end
            S_GW2: begin
                // new epilogue
                mem_cmd.wr = 1'b1;
                mem_addr   = bp_reg + size_reg - AW'(4);
                mem_wdata  = 32'd1;
                break_next = break_reg + size_reg;
                state_next = S_MPREV;
            end
            S_F1: begin
                tag_next  = mem_rdata;
                size_next = rd_size;
                if (mem_rdata[0] && rd_size >= MIN_BLK && rd_size <= break_reg - bp_reg) begin
                    mem_cmd.rd = 1'b1;
                    mem_addr   = bp_reg + rd_size - AW'(8);
                    state_next = S_F2;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_F2: begin
                if (mem_rdata == tag_reg) begin
                    mem_cmd.wr = 1'b1;
                    mem_addr   = bp_reg - AW'(4);
                    mem_wdata  = tag_of(size_reg, 1'b0);
                    state_next = S_F3;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_F3: begin
                mem_cmd.wr = 1'b1;
                mem_addr   = bp_reg + size_reg - AW'(8);
                mem_wdata  = tag_of(size_reg, 1'b0);
                state_next = S_MPREV;
            end
            S_MPREV: begin
                mem_cmd.rd = 1'b1;
                mem_addr   = bp_reg - AW'(8);
                state_next = S_MNEXT;
            end
            S_MNEXT: begin
                tag_next   = mem_rdata;
                mem_cmd.rd = 1'b1;
                mem_addr   = bp_reg + size_reg - AW'(4);
                state_next = S_MJOIN;
            end
            S_MJOIN: begin
                // coalesce with free neighbors
                if (tag_reg[0] && mem_rdata[0]) begin
                    state_next = (kind_reg == bth_pkg::KIND_ALLOC) ? S_P0 : S_DONE;
                end else begin
                    bp_next    = tag_reg[0] ? bp_reg : bp_reg - prev_size;
                    size_next  = msize;
                    mem_cmd.wr = 1'b1;
                    mem_addr   = (tag_reg[0] ? bp_reg : bp_reg - prev_size) - AW'(4);
                    mem_wdata  = tag_of(msize, 1'b0);
                    state_next = S_MFOOT;
                end
            end
            S_MFOOT: begin
                mem_cmd.wr = 1'b1;
                mem_addr   = bp_reg + size_reg - AW'(8);
                mem_wdata  = tag_of(size_reg, 1'b0);
                state_next = (kind_reg == bth_pkg::KIND_ALLOC) ? S_P0 : S_DONE;
            end
            S_P0: begin
                mem_cmd.wr = 1'b1;
                mem_addr   = bp_reg - AW'(4);
                mem_wdata  = tag_of(psize, 1'b1);
                state_next = S_P1;
            end
            S_P1: begin
                mem_cmd.wr              = 1'b1;
                mem_addr                = bp_reg + psize - AW'(8);
                mem_wdata               = tag_of(psize, 1'b1);
                res_next.payload_offset = bp_reg[15:0];
                state_next              = split ? S_P2 : S_DONE;
            end
            S_P2: begin
                // remainder block
                mem_cmd.wr = 1'b1;
                mem_addr   = bp_reg + need_reg - AW'(4);
                mem_wdata  = tag_of(size_reg - need_reg, 1'b0);
                state_next = S_P3;
            end
            S_P3: begin
                mem_cmd.wr = 1'b1;
                mem_addr   = bp_reg + size_reg - AW'(8);
                mem_wdata  = tag_of(size_reg - need_reg, 1'b0);
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            init_cnt_reg <= 2'd0;
            break_reg    <= AW'(16);
        end else begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            break_reg    <= break_next;
        end
        bp_reg   <= bp_next;
        need_reg <= need_next;
        size_reg <= size_next;
        tag_reg  <= tag_next;
        kind_reg <= kind_next;
        res_reg  <= res_next;
    end

endmodule

// ===== test/boundary_tag_heap_allocator_tb.sv =====
`timescale 1ns / 1ps

module boundary_tag_heap_allocator_tb;

    localparam int HEAP_WORDS = 16384;
    localparam int HEAP_BYTES = HEAP_WORDS * 4;
    localparam int MIN_BLOCK = 16;
    localparam longint CYCLE_LIMIT = 20000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    bth_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    bth_pkg::out_t m_data;
    logic cfg_we = 1'b0;
    logic [16:0] cfg_wdata = '0;

    boundary_tag_heap_allocator #(.HEAP_WORDS(HEAP_WORDS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // shadow heap used for prediction
    logic [31:0] shadow_heap [HEAP_WORDS];
    int unsigned shadow_break;
    int unsigned shadow_chunk;

    bth_pkg::in_t request_queue[$];
    bth_pkg::out_t expected_results[$];
    int unsigned live_blocks[$];
    int errors = 0;
    int results_seen = 0;
    int allocs_sent = 0;
    int frees_sent = 0;
    int full_seen = 0;
    int zero_seen = 0;
    longint cycle_count = 0;
    bit quiet_driver = 1'b0;
    bit quiet_sink = 1'b0;

    function automatic logic [31:0] heap_read(int unsigned addr);
        if ((addr >> 2) >= HEAP_WORDS) return 32'd0;
        return shadow_heap[addr >> 2];
    endfunction

    function automatic void heap_write(int unsigned addr, logic [31:0] val);
        if ((addr >> 2) < HEAP_WORDS) shadow_heap[addr >> 2] = val;
    endfunction

    function automatic void write_tags(int unsigned bp, int unsigned size, bit alloc);
        heap_write(bp - 4, size | alloc);
        heap_write(bp + size - 8, size | alloc);
    endfunction

    function automatic int unsigned coalesce(int unsigned bp);
        int unsigned size;
        logic [31:0] prev_tag;
        logic [31:0] next_tag;
        int unsigned start;
        size = heap_read(bp - 4) & ~32'h7;
        prev_tag = heap_read(bp - 8);
        next_tag = heap_read(bp + size - 4);
        start = bp;
        if (prev_tag[0] && next_tag[0]) return bp;
        if (!next_tag[0]) size += next_tag & ~32'h7;
        if (!prev_tag[0]) begin
            start = bp - (prev_tag & ~32'h7);
            size += prev_tag & ~32'h7;
        end
        write_tags(start, size, 1'b0);
        return start;
    endfunction

    function automatic void carve(int unsigned bp, int unsigned need);
        int unsigned have;
        have = heap_read(bp - 4) & ~32'h7;
        if (have < need + MIN_BLOCK) begin
            write_tags(bp, have, 1'b1);
        end else begin
            write_tags(bp, need, 1'b1);
            write_tags(bp + need, have - need, 1'b0);
        end
    endfunction

    function automatic void heap_init();
        foreach (shadow_heap[i]) shadow_heap[i] = '0;
        shadow_heap[1] = 32'd9;
        shadow_heap[2] = 32'd9;
        shadow_heap[3] = 32'd1;
        shadow_break = 16;
        shadow_chunk = bth_pkg::CHUNK_RESET;
    endfunction

    // compute the result of one request and update the shadow heap
    function automatic bth_pkg::out_t allocator_step(bth_pkg::in_t req);
        bth_pkg::out_t res;
        int unsigned need, bp, s, ext, words, size, off;
        logic [31:0] tag;
        bit found;
        res = '0;
        if (req.kind == bth_pkg::KIND_ALLOC) begin
            if (req.request_bytes == 0) begin
                res.status = bth_pkg::ST_ZERO;
            end else begin
                need = (req.request_bytes <= 8) ? MIN_BLOCK
                     : 8 * ((req.request_bytes + 15) / 8);
                found = 1'b0;
                bp = 8;
                while (bp < shadow_break) begin
                    tag = heap_read(bp - 4);
                    s = tag & ~32'h7;
                    if (s == 0) break;
                    if (!tag[0] && need <= s) begin
                        found = 1'b1;
                        break;
                    end
                    bp += s;
                end
                if (!found) begin
                    ext = (need > shadow_chunk) ? need : shadow_chunk;
                    words = ext >> 2;
                    if (words & 1) words++;
                    size = words * 4;
                    if (shadow_break <= HEAP_BYTES && size <= HEAP_BYTES - shadow_break) begin
                        bp = shadow_break;
                        write_tags(bp, size, 1'b0);
                        heap_write(bp + size - 4, 32'd1);
                        shadow_break += size;
                        bp = coalesce(bp);
                        found = 1'b1;
                    end
                end
                if (found) begin
                    carve(bp, need);
                    res.payload_offset = bp[15:0];
                end else begin
                    res.status = bth_pkg::ST_FULL;
                end
            end
        end else begin
            off = req.block_offset;
            if ((off & 7) == 0 && off >= 16 && off < shadow_break) begin
                tag = heap_read(off - 4);
                s = tag & ~32'h7;
                if (tag[0] && s >= MIN_BLOCK && s <= shadow_break - off
                        && heap_read(off + s - 8) == tag) begin
                    write_tags(off, s, 1'b0);
                    void'(coalesce(off));
                end
            end
        end
        return res;
    endfunction

    // driver: idles about 24% of cycles unless in a quiet stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // hold the transaction
        end else if (request_queue.size() > 0 &&
                (quiet_driver || $urandom_range(99) >= 24)) begin
            s_valid <= 1'b1;
            s_data <= request_queue.pop_front();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // predict on acceptance
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(allocator_step(s_data));
            if (s_data.kind == bth_pkg::KIND_ALLOC) allocs_sent++;
            else frees_sent++;
        end
    end

    // sink stall pattern
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= quiet_sink || ($urandom_range(99) >= 24);
    end

    // monitor: compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        bth_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("unexpected result: payload_offset %0d status %0d",
                       m_data.payload_offset, m_data.status);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (want.payload_offset !== m_data.payload_offset) begin
                    $error("payload_offset expected %0d actual %0d",
                           want.payload_offset, m_data.payload_offset);
                    errors++;
                end
                if (want.status !== m_data.status) begin
                    $error("status expected %0d actual %0d", want.status, m_data.status);
                    errors++;
                end
                if (want.status == bth_pkg::ST_FULL) full_seen++;
                if (want.status == bth_pkg::ST_ZERO) zero_seen++;
                if (want.status == bth_pkg::ST_OK && want.payload_offset != 0)
                    live_blocks.push_back(want.payload_offset);
            end
        end
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic bth_pkg::in_t make_alloc(int unsigned bytes);
        bth_pkg::in_t t;
        t = '0;
        t.kind = bth_pkg::KIND_ALLOC;
        t.request_bytes = bytes[16:0];
        t.block_offset = 16'($urandom);
        return t;
    endfunction

    function automatic bth_pkg::in_t make_free(int unsigned off);
        bth_pkg::in_t t;
        t = '0;
        t.kind = bth_pkg::KIND_FREE;
        t.request_bytes = 17'($urandom);
        t.block_offset = off[15:0];
        return t;
    endfunction

    function automatic int unsigned random_size();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60) return $urandom_range(1, 64);
        if (pick < 85) return $urandom_range(65, 1024);
        if (pick < 95) return $urandom_range(1025, 8192);
        if (pick < 98) return $urandom_range(8193, 65536);
        return 0;
    endfunction

    task automatic wait_drained();
        while (request_queue.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        // every request has given its result by now; idle a little before returning
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_chunk(int unsigned value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value[16:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        shadow_chunk = value & 17'h1FFFF;
    endtask

    // one phase of random traffic: half allocates, the rest mostly frees of live blocks
    task automatic random_phase(int count);
        int idx;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                request_queue.push_back(make_alloc(random_size()));
            end else if (pick < 88 && live_blocks.size() > 0) begin
                idx = $urandom_range(live_blocks.size() - 1);
                request_queue.push_back(make_free(live_blocks[idx]));
                live_blocks.delete(idx);
            end else if (pick < 94) begin
                request_queue.push_back(make_free($urandom_range(65535)));
            end else begin
                request_queue.push_back(make_free($urandom_range(2, 8191) * 8));
            end
            // keep live list coherent with issued frees: wait in small batches
            if (request_queue.size() > 8) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        heap_init();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (10) @(posedge aclk);

        // directed: size extremes, both kinds, invalid frees, exhaustion
        request_queue.push_back(make_alloc(0));
        request_queue.push_back(make_alloc(1));
        request_queue.push_back(make_alloc(8));
        request_queue.push_back(make_alloc(9));
        request_queue.push_back(make_alloc(4080));
        request_queue.push_back(make_free(16'hFFFF));
        request_queue.push_back(make_free(0));
        request_queue.push_back(make_free(8));
        request_queue.push_back(make_free(20));
        request_queue.push_back(make_free(65528));
        request_queue.push_back(make_free(32));
        request_queue.push_back(make_free(16));
        request_queue.push_back(make_free(32));
        request_queue.push_back(make_free(48));
        request_queue.push_back(make_alloc(65536));
        request_queue.push_back(make_alloc(70000 & 17'h1FFFF));
        request_queue.push_back(make_alloc(40000));
        request_queue.push_back(make_alloc(30000));
        request_queue.push_back(make_alloc(131071));
        wait_drained();
        live_blocks.delete();

        // small chunks, quiet stretch on both sides
        set_chunk(8);
        quiet_driver = 1'b1;
        quiet_sink = 1'b1;
        random_phase(300);
        quiet_driver = 1'b0;
        quiet_sink = 1'b0;
        set_chunk(17'h1FFFF);
        random_phase(200);
        set_chunk(12);
        random_phase(300);
        set_chunk(65536);
        random_phase(200);
        set_chunk($urandom_range(8, 2048));
        random_phase(500);

        repeat (100) @(posedge aclk);
        $display("ran %0d allocates and %0d frees, %0d results checked",
                 allocs_sent, frees_sent, results_seen);
        $display("%0d heap-full and %0d zero-size results seen", full_seen, zero_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
